@@ sv/kdpc_pkg.sv @@
// Shared types and constants for the key debounce and press classifier.
package kdpc_pkg;

  // Width of the hold counter.
  localparam int COUNT_WIDTH = 16;
  // Width of the threshold registers.
  localparam int THRESH_WIDTH = 16;
  // Compare width that holds both the counter and a threshold.
  localparam int CMP_WIDTH = (COUNT_WIDTH > THRESH_WIDTH) ? COUNT_WIDTH : THRESH_WIDTH;
  // Configuration index width and register indexes.
  localparam int CFG_IDX_WIDTH = 1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEBOUNCE_TICKS = 1'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_PRESS_TICKS = 1'd1;
  // Reset values of the threshold registers.
  localparam logic [THRESH_WIDTH-1:0] DEBOUNCE_RESET = 16'd1;
  localparam logic [THRESH_WIDTH-1:0] LONG_PRESS_RESET = 16'd50;
  // Saturation value of the hold counter.
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Scan machine modes.
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PRESSED = 2'd1,
    MODE_CONFIRM = 2'd2
  } scan_mode_t;

  // Press kinds.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2
  } press_kind_t;

  // One result item.
  typedef struct packed {
    logic        report_status;
    press_kind_t press_kind;
  } result_t;

  // Threshold settings handed from the register block to the core.
  typedef struct packed {
    logic [THRESH_WIDTH-1:0] debounce_ticks;
    logic [THRESH_WIDTH-1:0] long_press_ticks;
  } thresh_t;

endpackage

@@ sv/kdpc_cfg.sv @@
// Configuration registers holding the debounce and long press thresholds.
module kdpc_cfg
  import kdpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [THRESH_WIDTH-1:0]  cfg_data,
  output thresh_t                  thresh
);

  logic [THRESH_WIDTH-1:0] debounce_r;
  logic [THRESH_WIDTH-1:0] long_press_r;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register write decode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RESET;
      long_press_r <= LONG_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_TICKS:   debounce_r   <= cfg_data;
        CFG_LONG_PRESS_TICKS: long_press_r <= cfg_data;
        default:              ;
      endcase
    end
  end

  assign thresh.debounce_ticks   = debounce_r;
  assign thresh.long_press_ticks = long_press_r;

endmodule

@@ sv/kdpc_core.sv @@
// Scan state machine that debounces the key and classifies each press.
module kdpc_core
  import kdpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    accept,
  input  logic    key_level,
  input  thresh_t thresh,
  output result_t result
);

  scan_mode_t             mode_r, mode_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  press_kind_t            pending_r, pending_nxt;

  logic                   pressed;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [CMP_WIDTH-1:0]   count_inc_x;
  logic [CMP_WIDTH-1:0]   count_x;
  logic [CMP_WIDTH-1:0]   debounce_x;
  logic [CMP_WIDTH-1:0]   long_x;

  assign pressed = ~key_level;

  // Saturating increment, and operands widened to a common compare width.
  assign count_inc   = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;
  assign count_inc_x = CMP_WIDTH'(count_inc);
  assign count_x     = CMP_WIDTH'(count_r);
  assign debounce_x  = CMP_WIDTH'(thresh.debounce_ticks);
  assign long_x      = CMP_WIDTH'(thresh.long_press_ticks);

  // Next state of the scan machine.
  always_comb begin
    mode_nxt    = mode_r;
    count_nxt   = count_r;
    pending_nxt = pending_r;
    unique case (mode_r)
      MODE_PRESSED: begin
        if (pressed) begin
          count_nxt = count_inc;
          if (count_inc_x > long_x) begin
            mode_nxt    = MODE_CONFIRM;
            pending_nxt = KIND_LONG;
          end
        end else if (count_x <= long_x && count_x > debounce_x) begin
          mode_nxt    = MODE_CONFIRM;
          pending_nxt = KIND_SHORT;
        end else begin
          mode_nxt  = MODE_IDLE;
          count_nxt = '0;
        end
      end
      MODE_CONFIRM: begin
        mode_nxt    = MODE_IDLE;
        count_nxt   = '0;
        pending_nxt = KIND_NONE;
      end
      default: begin
        // Idle, and the unused code behaves as idle.
        mode_nxt = MODE_IDLE;
        if (pressed) begin
          if (count_inc_x > debounce_x) begin
            count_nxt = '0;
            mode_nxt  = MODE_PRESSED;
          end else begin
            count_nxt = count_inc;
          end
        end else begin
          count_nxt = '0;
        end
      end
    endcase
  end

  // Result of the current item: a report only from the confirm mode.
  always_comb begin
    result.report_status = 1'b0;
    result.press_kind    = KIND_NONE;
    if (mode_r == MODE_CONFIRM) begin
      result.report_status = 1'b1;
      result.press_kind    = pending_r;
    end
  end

  // State registers advance once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      count_r   <= '0;
      pending_r <= KIND_NONE;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      count_r   <= count_nxt;
      pending_r <= pending_nxt;
    end
  end

  // A pending kind is held exactly while a report waits in confirm mode.
  a_pending_only_in_confirm: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_CONFIRM) |-> (pending_r == KIND_NONE))
    else $error("pending kind set outside confirm mode");

  a_confirm_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_CONFIRM) |-> (pending_r == KIND_SHORT || pending_r == KIND_LONG))
    else $error("confirm mode without a press kind");

  // A report returns the machine to idle with a cleared counter.
  a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode_r == MODE_CONFIRM) |=> (mode_r == MODE_IDLE && count_r == '0))
    else $error("machine not cleared after a report");

  // State holds while no item is accepted.
  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ($stable(mode_r) && $stable(count_r) && $stable(pending_r)))
    else $error("state changed without an accepted item");

endmodule

@@ sv/kdpc_out.sv @@
// Result register with a skid stage between the core and the result channel.
module kdpc_out
  import kdpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // Buffer update: the skid item moves up first, a new item fills the
  // main register when it frees up and the skid register otherwise.
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  // The skid register is only occupied behind a held result.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid item without a main item");

  // The core never pushes into a full buffer.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("item pushed into a full buffer");

  // A filled skid register drains into the main register on a pop.
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> (main_valid_r && !skid_valid_r && main_r == $past(skid_r)))
    else $error("skid item lost");

endmodule

@@ sv/key_debounce_press_classifier_top.sv @@
// Top level of the key debounce and short/long press classifier.
// Each input item is one sampled key level (0 pressed, 1 released) for one scan
// tick, and every item yields exactly one result item: report_status 1 with the
// press kind (1 short, 2 long) on the tick after a press is classified, and 0/0
// otherwise. An item is taken every cycle while in_stall is low; its result, formed
// from the scan state registers, enters the output buffer on acceptance. A
// two-entry output buffer lets the block keep accepting while one result waits, so
// in_stall rises only when two results are held back. Thresholds are written over
// the cfg port (index 0 debounce ticks, index 1 long press ticks) by the user only
// while no items are in flight; the block does not enforce this.
module key_debounce_press_classifier_top
  import kdpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_key_level,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_report_status,
  output logic [1:0]               out_press_kind,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [THRESH_WIDTH-1:0]  cfg_data
);

  thresh_t thresh;
  result_t core_result;
  result_t out_data;
  logic    accept;
  logic    buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  kdpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thresh    (thresh)
  );

  kdpc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .key_level (in_key_level),
    .thresh    (thresh),
    .result    (core_result)
  );

  kdpc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (core_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_report_status = out_data.report_status;
  assign out_press_kind    = out_data.press_kind;

endmodule
